@@ rtl/core/calu_pkg.sv @@
// shared types, codes and constants for the conditional alu with barrel shifter
// no dependencies; imported by every module in rtl/core
package calu_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [7:0]  AMT_MASK    = 8'hFF;
  localparam logic [4:0]  IMM_AMT_MAX = 5'd31;

  typedef enum logic [3:0] {
    OP_AND = 4'd0,  OP_EOR = 4'd1,  OP_SUB = 4'd2,  OP_RSB = 4'd3,
    OP_ADD = 4'd4,  OP_ADC = 4'd5,  OP_SBC = 4'd6,  OP_RSC = 4'd7,
    OP_TST = 4'd8,  OP_TEQ = 4'd9,  OP_CMP = 4'd10, OP_CMN = 4'd11,
    OP_ORR = 4'd12, OP_MOV = 4'd13, OP_BIC = 4'd14, OP_MVN = 4'd15
  } calu_opcode_t;

  typedef enum logic [3:0] {
    CC_EQ = 4'd0,  CC_NE = 4'd1,  CC_CS = 4'd2,  CC_CC = 4'd3,
    CC_MI = 4'd4,  CC_PL = 4'd5,  CC_VS = 4'd6,  CC_VC = 4'd7,
    CC_HI = 4'd8,  CC_LS = 4'd9,  CC_GE = 4'd10, CC_LT = 4'd11,
    CC_GT = 4'd12, CC_LE = 4'd13, CC_AL = 4'd14, CC_NV = 4'd15
  } calu_cond_t;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0, SH_LSR = 2'd1, SH_ASR = 2'd2, SH_ROR = 2'd3
  } calu_shift_t;

  typedef struct packed {
    logic [3:0]        condition;
    logic [3:0]        alu_op;
    logic              set_flags;
    logic [DATA_W-1:0] first_operand;
    logic              use_immediate;
    logic [DATA_W-1:0] immediate_value;
    logic [DATA_W-1:0] shifted_value;
    logic [1:0]        shift_kind;
    logic [7:0]        shift_amount;
    logic              shift_by_register;
  } calu_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic              write_result;
    logic              condition_passed;
    logic [3:0]        flags_out;
  } calu_out_t;

  // classified transaction handed from front to back
  typedef struct packed {
    calu_cond_t        condition;
    calu_opcode_t      alu_op;
    logic              set_flags;
    logic [DATA_W-1:0] first_operand;
    logic [DATA_W-1:0] operand_b;
    logic              b_carry;
    logic              carry_keep;  // shifter carry is the current c flag
    logic              rrx_top;     // bit 31 of operand b is the current c flag
    logic              is_test;
  } calu_op_t;

endpackage

@@ rtl/core/calu_front.sv @@
// front stage: accepts transactions, runs the barrel shifter and classifies the opcode
// depends on calu_pkg
module calu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  calu_pkg::calu_in_t in_data,
  output logic               fe_valid,
  input  logic               fe_ready,
  output calu_pkg::calu_op_t fe_data
);
  import calu_pkg::*;

  logic              vld_r, vld_nxt;
  calu_op_t          op_r, op_nxt;
  logic [DATA_W-1:0] val;
  logic              sign;
  logic [4:0]        a5;
  logic [7:0]        n;
  logic [DATA_W:0]   lsl_w, lsr_w, asr_w;
  logic [2*DATA_W-1:0] ror_w;
  logic [DATA_W-1:0] sh_val;
  logic              sh_c, sh_keep, sh_rrx;

  assign val  = in_data.shifted_value;
  assign sign = val[DATA_W-1];
  assign a5   = in_data.shift_amount[4:0] & IMM_AMT_MAX;
  assign n    = in_data.shift_by_register ? (in_data.shift_amount & AMT_MASK) : {3'b000, a5};

  // extra bit on the shifted-out side holds the carry for amounts 1..31
  assign lsl_w = {1'b0, val} << n[4:0];
  assign lsr_w = {val, 1'b0} >> n[4:0];
  assign asr_w = $unsigned($signed({val, 1'b0}) >>> n[4:0]);
  assign ror_w = {val, val} >> n[4:0];

  always_comb begin
    sh_val  = val;
    sh_c    = 1'b0;
    sh_keep = 1'b0;
    sh_rrx  = 1'b0;
    if (in_data.use_immediate) begin
      sh_val  = in_data.immediate_value;
      sh_keep = 1'b1;
    end else if (!in_data.shift_by_register && a5 == 5'd0) begin
      case (calu_shift_t'(in_data.shift_kind))
        SH_LSL: begin
          sh_keep = 1'b1;
        end
        SH_LSR: begin
          sh_val = '0;
          sh_c   = sign;
        end
        SH_ASR: begin
          sh_val = {DATA_W{sign}};
          sh_c   = sign;
        end
        default: begin
          // rrx: top bit filled with the c flag in the back stage
          sh_val = {1'b0, val[DATA_W-1:1]};
          sh_c   = val[0];
          sh_rrx = 1'b1;
        end
      endcase
    end else if (n == 8'd0) begin
      sh_keep = 1'b1;
    end else begin
      case (calu_shift_t'(in_data.shift_kind))
        SH_LSL: begin
          if (n < 8'd32) begin
            sh_val = lsl_w[DATA_W-1:0];
            sh_c   = lsl_w[DATA_W];
          end else begin
            sh_val = '0;
            sh_c   = (n == 8'd32) ? val[0] : 1'b0;
          end
        end
        SH_LSR: begin
          if (n < 8'd32) begin
            sh_val = lsr_w[DATA_W:1];
            sh_c   = lsr_w[0];
          end else begin
            sh_val = '0;
            sh_c   = (n == 8'd32) ? sign : 1'b0;
          end
        end
        SH_ASR: begin
          if (n < 8'd32) begin
            sh_val = asr_w[DATA_W:1];
            sh_c   = asr_w[0];
          end else begin
            sh_val = {DATA_W{sign}};
            sh_c   = sign;
          end
        end
        default: begin
          if (n[4:0] == 5'd0) begin
            sh_val = val;
            sh_c   = sign;
          end else begin
            sh_val = ror_w[DATA_W-1:0];
            sh_c   = ror_w[DATA_W-1];
          end
        end
      endcase
    end
  end

  assign in_ready = !vld_r || fe_ready;

  always_comb begin
    vld_nxt = vld_r;
    op_nxt  = op_r;
    if (in_ready) begin
      vld_nxt = in_valid;
      if (in_valid) begin
        op_nxt.condition     = calu_cond_t'(in_data.condition);
        op_nxt.alu_op        = calu_opcode_t'(in_data.alu_op);
        op_nxt.set_flags     = in_data.set_flags;
        op_nxt.first_operand = in_data.first_operand;
        op_nxt.operand_b     = sh_val;
        op_nxt.b_carry       = sh_c;
        op_nxt.carry_keep    = sh_keep;
        op_nxt.rrx_top       = sh_rrx;
        op_nxt.is_test       = (in_data.alu_op[3:2] == 2'b10);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
  end

  assign fe_valid = vld_r;
  assign fe_data  = op_r;

endmodule

@@ rtl/core/calu_queue.sv @@
// short fifo of classified transactions between front and back stage
// depends on calu_pkg
module calu_queue #(
  parameter int unsigned DEPTH = calu_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  calu_pkg::calu_op_t wr_data,
  output logic               rd_valid,
  input  logic               rd_ready,
  output calu_pkg::calu_op_t rd_data
);
  import calu_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  calu_op_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign wr_ready = (cnt_r != FULL);
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= FULL)
    else $error("queue count above depth");
  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count missed a push");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> wr_ptr_r == rd_ptr_r)
    else $error("empty queue with pointers apart");

endmodule

@@ rtl/core/calu_back.sv @@
// back stage: condition check, alu, nzcv flag register and output register
// depends on calu_pkg
module calu_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  calu_pkg::calu_op_t  q_data,
  output logic                out_valid,
  input  logic                out_ready,
  output calu_pkg::calu_out_t out_data
);
  import calu_pkg::*;

  logic [3:0]        flags_r, flags_nxt;
  logic              out_vld_r, out_vld_nxt;
  calu_out_t         out_r, out_nxt;
  logic              pop, cond_ok, fn, fz, fc, fv;
  logic [DATA_W-1:0] a, b, x, y, r;
  logic [DATA_W:0]   sum;
  logic              add_cin, sc, c, v, use_add, update;

  assign fn = flags_r[3];
  assign fz = flags_r[2];
  assign fc = flags_r[1];
  assign fv = flags_r[0];

  assign q_ready = !out_vld_r || out_ready;
  assign pop     = q_valid && q_ready;

  always_comb begin
    unique case (q_data.condition)
      CC_EQ: cond_ok = fz;
      CC_NE: cond_ok = !fz;
      CC_CS: cond_ok = fc;
      CC_CC: cond_ok = !fc;
      CC_MI: cond_ok = fn;
      CC_PL: cond_ok = !fn;
      CC_VS: cond_ok = fv;
      CC_VC: cond_ok = !fv;
      CC_HI: cond_ok = fc && !fz;
      CC_LS: cond_ok = !fc || fz;
      CC_GE: cond_ok = (fn == fv);
      CC_LT: cond_ok = (fn != fv);
      CC_GT: cond_ok = !fz && (fn == fv);
      CC_LE: cond_ok = fz || (fn != fv);
      CC_AL: cond_ok = 1'b1;
      default: cond_ok = 1'b0;
    endcase
  end

  assign a  = q_data.first_operand;
  assign b  = {q_data.rrx_top ? fc : q_data.operand_b[DATA_W-1], q_data.operand_b[DATA_W-2:0]};
  assign sc = q_data.carry_keep ? fc : q_data.b_carry;

  // one shared adder for all arithmetic opcodes
  always_comb begin
    x       = a;
    y       = b;
    add_cin = 1'b0;
    use_add = 1'b1;
    unique case (q_data.alu_op)
      OP_SUB, OP_CMP: begin y = ~b; add_cin = 1'b1; end
      OP_RSB:         begin x = b; y = ~a; add_cin = 1'b1; end
      OP_ADD, OP_CMN: begin add_cin = 1'b0; end
      OP_ADC:         begin add_cin = fc; end
      OP_SBC:         begin y = ~b; add_cin = fc; end
      OP_RSC:         begin x = b; y = ~a; add_cin = fc; end
      default:        begin use_add = 1'b0; end
    endcase
  end

  assign sum = {1'b0, x} + {1'b0, y} + {{DATA_W{1'b0}}, add_cin};

  always_comb begin
    r = sum[DATA_W-1:0];
    unique case (q_data.alu_op)
      OP_AND, OP_TST: r = a & b;
      OP_EOR, OP_TEQ: r = a ^ b;
      OP_ORR:         r = a | b;
      OP_MOV:         r = b;
      OP_BIC:         r = a & ~b;
      OP_MVN:         r = ~b;
      default:        r = sum[DATA_W-1:0];
    endcase
  end

  assign c      = use_add ? sum[DATA_W] : sc;
  assign v      = use_add ? (~(x[DATA_W-1] ^ y[DATA_W-1]) & (x[DATA_W-1] ^ r[DATA_W-1])) : fv;
  assign update = cond_ok && (q_data.set_flags || q_data.is_test);

  always_comb begin
    flags_nxt   = flags_r;
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    if (pop && update) flags_nxt = {r[DATA_W-1], (r == '0), c, v};
    if (q_ready) begin
      out_vld_nxt = q_valid;
      if (q_valid) begin
        out_nxt.result           = cond_ok ? r : '0;
        out_nxt.write_result     = cond_ok && !q_data.is_test;
        out_nxt.condition_passed = cond_ok;
        out_nxt.flags_out        = update ? {r[DATA_W-1], (r == '0), c, v} : flags_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      flags_r   <= flags_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_fail_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !cond_ok |=> $stable(flags_r))
    else $error("flags changed on a failed condition");
  a_flags_only_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !pop |=> $stable(flags_r))
    else $error("flags changed without a transaction");
  a_out_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_r.flags_out == flags_r)
    else $error("reported flags differ from flag register");

endmodule

@@ rtl/core/conditional_alu_with_barrel_shifter_core.sv @@
// top level of the conditional alu with barrel shifter
// depends on calu_pkg, calu_front, calu_queue, calu_back
//
//   channel | ports                          | direction | moves
//   input   | in_valid, in_ready, in_data    | in        | one instruction transaction
//   output  | out_valid, out_ready, out_data | out       | one result transaction
//
// one transaction per cycle sustained when nothing stalls; each transaction passes the front
// register, a queue entry and the output register
// the condition check, alu and nzcv update all sit in the back stage, and nzcv is written
// as the transaction leaves the queue, so each transaction sees the flags of the one before
// rst_n is synchronous; it empties the pipeline and clears nzcv to zero
// a stalled output fills the output register, then the queue, then the front register
module conditional_alu_with_barrel_shifter_core #(
  parameter int unsigned QUEUE_DEPTH = calu_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  calu_pkg::calu_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output calu_pkg::calu_out_t out_data
);
  import calu_pkg::*;

  logic     fe_valid, fe_ready, q_valid, q_ready;
  calu_op_t fe_data, q_data;

  calu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .fe_valid (fe_valid),
    .fe_ready (fe_ready),
    .fe_data  (fe_data)
  );

  calu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fe_valid),
    .wr_ready (fe_ready),
    .wr_data  (fe_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  calu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
